[rtl/core/shc_pkg.sv]
// ----------------------------------------------------------------------------
// shc_pkg
// Shared types and codes for the subset hypothesis classifier: action and
// status codes, sequencer states, register indexes and the scan step word.
// ----------------------------------------------------------------------------
package shc_pkg;

  // fixed field widths
  localparam int CNT_W    = 6;   // attr_count, prop_count
  localparam int SUM_W    = 7;   // attr_count + prop_count
  localparam int IN_W     = 64;  // set_bits field
  localparam int MATCH_W  = 32;  // match mask fields
  localparam int ACT_W    = 64;  // activity field
  localparam int POS_W    = 5;   // bit position inside a match mask

  // register reset values
  localparam logic [CNT_W-1:0] ATTR_RESET = 6'd32;
  localparam logic [CNT_W-1:0] PROP_RESET = 6'd8;

  // configuration register indexes
  localparam logic CFG_ATTR_COUNT = 1'b0;
  localparam logic CFG_PROP_COUNT = 1'b1;

  // input actions
  typedef enum logic [1:0] {
    ACT_LOAD_PLUS  = 2'd0,
    ACT_LOAD_MINUS = 2'd1,
    ACT_CLASSIFY   = 2'd2,
    ACT_CLEAR      = 2'd3
  } action_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_LOADED     = 2'd0,
    STAT_FULL       = 2'd1,
    STAT_CLASSIFIED = 2'd2,
    STAT_CLEARED    = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH,
    S_RESP
  } state_t;

  // one scan step, aligned with the table read data
  typedef struct packed {
    logic             plus_en;
    logic             minus_en;
    logic [POS_W-1:0] pos;
  } scan_step_t;

endpackage

[rtl/core/subset_hypothesis_classifier.sv]
// ----------------------------------------------------------------------------
// subset_hypothesis_classifier
// Two tables of bit-set hypotheses (plus, minus) with load, clear and
// classify words; classify reports the matching subsets and property pairs.
// ----------------------------------------------------------------------------
// Usage
//   s_* channel: one word per item, tuser = action, tdata = set_bits.
//   m_* channel: one word per item, tuser = status, tdata = plus_match_mask,
//     minus_match_mask, activity from the low bit up.
//   cfg_* channel: register writes (index 0 attr_count, 1 prop_count), always
//     ready; write only while no item is in flight.
//   Load and clear words pass from the idle state to the response state
//   and then to the output register. For a classify word the sequencer
//   walks every table row once, reading the plus and minus memory
//   at the same row each cycle into the one shared subset compare unit,
//   then the finish state forms the activity pairs with a barrel shift.
//   s_tready is high only while the sequencer is idle, so one item is worked
//   on at a time; the result register lets the next item be accepted while
//   a result waits. If m_tready stays low the sequencer holds its result
//   until the output register frees up.
//   Reset empties both tables (fill counts to zero) and restores the
//   registers to attr_count 32, prop_count 8; table contents need no clear.
// ----------------------------------------------------------------------------
module subset_hypothesis_classifier import shc_pkg::*; #(
  parameter int SET_BITS    = 64,
  parameter int TABLE_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  // input words
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [IN_W-1:0]     s_tdata,   // [63:0] set_bits
  input  logic [1:0]          s_tuser,   // [1:0] action
  // result words
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [127:0]        m_tdata,   // [31:0] plus_match_mask,
                                         // [63:32] minus_match_mask,
                                         // [127:64] activity
  output logic [1:0]          m_tuser,   // [1:0] status
  // configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [CNT_W-1:0]    cfg_data
);

  localparam int IDXW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

  state_t              state;
  state_t              state_next;
  logic [CNT_W-1:0]    attr_count;
  logic [CNT_W-1:0]    prop_count;
  logic [FILL_W-1:0]   plus_fill;
  logic [FILL_W-1:0]   minus_fill;
  logic [IDXW-1:0]     idx;
  scan_step_t          step;
  logic                in_fire;
  action_t             action;
  logic [SUM_W-1:0]    set_len;
  logic [SET_BITS-1:0] set_mask;
  logic [SET_BITS-1:0] in_set;
  logic [SUM_W-1:0]    act_len;
  logic [ACT_W-1:0]    act_mask;
  logic [ACT_W-1:0]    act_value;
  logic                plus_we;
  logic                minus_we;
  logic                match_start;
  logic                out_free;
  logic [SET_BITS-1:0] plus_word;
  logic [SET_BITS-1:0] minus_word;
  logic [SET_BITS-1:0] reduced;
  logic [MATCH_W-1:0]  plus_hits;
  logic [MATCH_W-1:0]  minus_hits;
  status_t             res_status;
  logic [MATCH_W-1:0]  res_plus;
  logic [MATCH_W-1:0]  res_minus;
  logic [ACT_W-1:0]    res_act;

  assign cfg_ready = 1'b1;
  assign in_fire   = s_tvalid && s_tready;
  assign action    = action_t'(s_tuser);
  assign out_free  = !m_tvalid || m_tready;

  // set mask and activity mask from the registers
  always_comb begin
    set_len = SUM_W'(attr_count) + SUM_W'(prop_count);
    act_len = (SUM_W'(prop_count) + SUM_W'(1)) & ~SUM_W'(1);
    for (int k = 0; k < SET_BITS; k++) begin
      set_mask[k] = set_len > SUM_W'(k);
    end
    for (int k = 0; k < ACT_W; k++) begin
      act_mask[k] = act_len > SUM_W'(k);
    end
    in_set    = s_tdata[SET_BITS-1:0] & set_mask;
    act_value = (ACT_W'(reduced) >> attr_count) & act_mask;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      attr_count <= ATTR_RESET;
      prop_count <= PROP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ATTR_COUNT: attr_count <= cfg_data;
        CFG_PROP_COUNT: prop_count <= cfg_data;
        default:        ;
      endcase
    end
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and control
  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    plus_we     = 1'b0;
    minus_we    = 1'b0;
    match_start = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          unique case (action)
            ACT_LOAD_PLUS: begin
              plus_we    = plus_fill < FILL_W'(TABLE_DEPTH);
              state_next = S_RESP;
            end
            ACT_LOAD_MINUS: begin
              minus_we   = minus_fill < FILL_W'(TABLE_DEPTH);
              state_next = S_RESP;
            end
            ACT_CLASSIFY: begin
              match_start = 1'b1;
              state_next  = S_SCAN;
            end
            default: state_next = S_RESP;
          endcase
        end
      end
      S_SCAN: begin
        if (idx == IDXW'(TABLE_DEPTH - 1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN:  state_next = S_FINISH;
      S_FINISH: state_next = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // fill counts
  always_ff @(posedge clk) begin
    if (rst) begin
      plus_fill  <= '0;
      minus_fill <= '0;
    end else if (in_fire && action == ACT_CLEAR) begin
      plus_fill  <= '0;
      minus_fill <= '0;
    end else begin
      if (plus_we) begin
        plus_fill <= plus_fill + FILL_W'(1);
      end
      if (minus_we) begin
        minus_fill <= minus_fill + FILL_W'(1);
      end
    end
  end

  // row counter and scan step aligned with the read data
  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      step <= '0;
    end else begin
      step.plus_en  <= (state == S_SCAN) && (FILL_W'(idx) < plus_fill);
      step.minus_en <= (state == S_SCAN) && (FILL_W'(idx) < minus_fill);
      step.pos      <= POS_W'(idx);
      if (state == S_SCAN) begin
        idx <= idx + IDXW'(1);
      end else begin
        idx <= '0;
      end
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_plus  <= '0;
      res_minus <= '0;
      res_act   <= '0;
      unique case (action)
        ACT_LOAD_PLUS:  res_status <= plus_we ? STAT_LOADED : STAT_FULL;
        ACT_LOAD_MINUS: res_status <= minus_we ? STAT_LOADED : STAT_FULL;
        ACT_CLASSIFY:   res_status <= STAT_CLASSIFIED;
        default:        res_status <= STAT_CLEARED;
      endcase
    end else if (state == S_FINISH) begin
      res_plus  <= plus_hits;
      res_minus <= minus_hits;
      res_act   <= act_value;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_RESP && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && out_free) begin
      m_tuser <= res_status;
      m_tdata <= {res_act, res_minus, res_plus};
    end
  end

  // hypothesis tables
  shc_table #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (SET_BITS),
    .IDXW  (IDXW)
  ) u_plus_table (
    .clk   (clk),
    .we    (plus_we),
    .waddr (plus_fill[IDXW-1:0]),
    .wdata (in_set),
    .raddr (idx),
    .rdata (plus_word)
  );

  shc_table #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (SET_BITS),
    .IDXW  (IDXW)
  ) u_minus_table (
    .clk   (clk),
    .we    (minus_we),
    .waddr (minus_fill[IDXW-1:0]),
    .wdata (in_set),
    .raddr (idx),
    .rdata (minus_word)
  );

  // shared subset compare unit
  shc_match #(
    .WIDTH (SET_BITS)
  ) u_match (
    .clk        (clk),
    .start      (match_start),
    .example    (in_set),
    .set_mask   (set_mask),
    .step       (step),
    .plus_word  (plus_word),
    .minus_word (minus_word),
    .reduced    (reduced),
    .plus_hits  (plus_hits),
    .minus_hits (minus_hits)
  );

  // fill counts never pass the table depth
  assert property (@(posedge clk) disable iff (rst)
    plus_fill <= FILL_W'(TABLE_DEPTH) && minus_fill <= FILL_W'(TABLE_DEPTH))
    else $error("fill count past table depth");

  // a new result appears only from the response state
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_RESP)
    else $error("result word without response state");

  // no match bit at or above the fill count
  assert property (@(posedge clk) disable iff (rst)
    state == S_FINISH |-> ((plus_hits >> plus_fill) == '0 &&
                           (minus_hits >> minus_fill) == '0))
    else $error("match bit beyond filled rows");

  // a clear word empties both tables
  assert property (@(posedge clk) disable iff (rst)
    in_fire && action == ACT_CLEAR |=> plus_fill == '0 && minus_fill == '0)
    else $error("tables not empty after clear");

endmodule

[rtl/core/shc_table.sv]
// ----------------------------------------------------------------------------
// shc_table
// Hypothesis table memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module shc_table import shc_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 64,
  parameter int IDXW  = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDXW-1:0]  waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [IDXW-1:0]  raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/shc_match.sv]
// ----------------------------------------------------------------------------
// shc_match
// Shared subset compare unit. Each step checks one plus and one minus entry
// against the example, sets their match bits and narrows the reduced set.
// ----------------------------------------------------------------------------
module shc_match import shc_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic               clk,
  input  logic               start,
  input  logic [WIDTH-1:0]   example,
  input  logic [WIDTH-1:0]   set_mask,
  input  scan_step_t         step,
  input  logic [WIDTH-1:0]   plus_word,
  input  logic [WIDTH-1:0]   minus_word,
  output logic [WIDTH-1:0]   reduced,
  output logic [MATCH_W-1:0] plus_hits,
  output logic [MATCH_W-1:0] minus_hits
);

  logic [WIDTH-1:0]   ex;
  logic [WIDTH-1:0]   plus_h;
  logic [WIDTH-1:0]   minus_h;
  logic               plus_hit;
  logic               minus_hit;
  logic [WIDTH-1:0]   reduced_next;
  logic [MATCH_W-1:0] bit_sel;

  function automatic logic minus_en_ok(input logic en, input logic [WIDTH-1:0] h,
                                       input logic [WIDTH-1:0] e);
    return en && ((h & ~e) == '0);
  endfunction

  // subset tests on the masked entries
  always_comb begin
    plus_h       = plus_word & set_mask;
    minus_h      = minus_word & set_mask;
    plus_hit     = step.plus_en && ((plus_h & ~ex) == '0);
    minus_hit    = minus_en_ok(step.minus_en, minus_h, ex);
    bit_sel      = MATCH_W'(1) << step.pos;
    reduced_next = reduced;
    if (plus_hit) begin
      reduced_next = reduced_next & plus_h;
    end
    if (minus_hit) begin
      reduced_next = reduced_next & minus_h;
    end
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (start) begin
      ex         <= example;
      reduced    <= example;
      plus_hits  <= '0;
      minus_hits <= '0;
    end else begin
      reduced <= reduced_next;
      if (plus_hit) begin
        plus_hits <= plus_hits | bit_sel;
      end
      if (minus_hit) begin
        minus_hits <= minus_hits | bit_sel;
      end
    end
  end

endmodule
